>>> hw/rtl/gamepad_report_decoder_top_macros.svh
// Assertion macros shared by the gamepad report decoder RTL.
// Standalone header: no dependencies.
`ifndef GAMEPAD_REPORT_DECODER_TOP_MACROS_SVH
`define GAMEPAD_REPORT_DECODER_TOP_MACROS_SVH

// Property holds at every clock edge outside reset.
`define GRD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("gamepad report decoder: assertion failed");

// Consequent holds on the edge after the antecedent.
`define GRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gamepad report decoder: assertion failed");

`endif

>>> hw/rtl/grd_pkg.sv
// Shared types and constants for the gamepad report decoder.
// No dependencies.
package grd_pkg;

	// Bytes 0..19 are the only ones any layout reads.
	localparam int unsigned StoreBytes = 20;

	localparam logic [2:0] FmtGip16    = 3'd0;
	localparam logic [2:0] FmtX360     = 3'd1;
	localparam logic [2:0] FmtDs4      = 3'd2;
	localparam logic [2:0] FmtDs3      = 3'd3;
	localparam logic [2:0] FmtDs5      = 3'd4;
	localparam logic [2:0] FmtPacked12 = 3'd5;

	typedef logic [StoreBytes-1:0][7:0] report_bytes_t;

	typedef struct packed {
		logic [1:0][7:0]  triggers;	// 0 left, 1 right
		logic [3:0][15:0] axes;		// 0 lx, 1 ly, 2 rx, 3 ry
		logic [13:0]      buttons;
	} pad_state_t;

endpackage

>>> hw/rtl/grd_capture.sv
// Input register, report byte store and length counter.
// Depends on grd_pkg and gamepad_report_decoder_top_macros.svh.
`include "gamepad_report_decoder_top_macros.svh"

module grd_capture #(
	parameter int unsigned REPORT_MAX_BYTES = 64,
	parameter int unsigned CNT_W = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  logic                  slot_free,	// result register can take a result
	output logic                  frame_done,	// final byte leaves the input register
	output logic [CNT_W-1:0]      frame_len,
	output grd_pkg::report_bytes_t frame_bytes
);
	import grd_pkg::*;

	logic             valid_s1;
	logic             last_s1;
	logic [7:0]       data_s1;
	logic [CNT_W-1:0] count_q;
	report_bytes_t    store_q;
	logic             advance;
	logic             count_sat;

	// Non-final bytes never wait: they yield no result.
	assign advance   = valid_s1 && (!last_s1 || slot_free);
	assign in_ready  = !valid_s1 || advance;
	assign count_sat = (count_q >= CNT_W'(REPORT_MAX_BYTES));

	assign frame_done = advance && last_s1;
	assign frame_len  = count_sat ? count_q : count_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			count_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
				last_s1  <= in_last;
			end
			if (advance) begin
				if (last_s1) begin
					count_q <= '0;
				end else if (!count_sat) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_byte;
		end
		if (advance) begin
			for (int i = 0; i < StoreBytes; i++) begin
				if (count_q == CNT_W'(i)) begin
					store_q[i] <= data_s1;
				end
			end
		end
	end

	// Final byte is not yet in the store: bypass it into the decode view.
	always_comb begin
		for (int i = 0; i < StoreBytes; i++) begin
			frame_bytes[i] = (count_q == CNT_W'(i)) ? data_s1 : store_q[i];
		end
	end

	`GRD_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(REPORT_MAX_BYTES))
	`GRD_ASSERT_NEXT(a_count_clear, clk, arst_n, frame_done, count_q == '0)

endmodule

>>> hw/rtl/grd_decode.sv
// Layout decode of one captured report into buttons, sticks and triggers.
// Depends on grd_pkg.
module grd_decode #(
	parameter int unsigned CNT_W = 7
) (
	input  logic [2:0]             pad_format,
	input  logic [CNT_W-1:0]       frame_len,
	input  grd_pkg::report_bytes_t frame_bytes,
	output grd_pkg::pad_state_t    pad_state,
	output logic                   report_ok
);
	import grd_pkg::*;

	localparam int unsigned BtnUp    = 0;
	localparam int unsigned BtnDown  = 1;
	localparam int unsigned BtnLeft  = 2;
	localparam int unsigned BtnRight = 3;
	localparam int unsigned BtnStart = 4;
	localparam int unsigned BtnBack  = 5;
	localparam int unsigned BtnL3    = 6;
	localparam int unsigned BtnR3    = 7;
	localparam int unsigned BtnLb    = 8;
	localparam int unsigned BtnRb    = 9;
	localparam int unsigned BtnA     = 10;
	localparam int unsigned BtnB     = 11;
	localparam int unsigned BtnX     = 12;
	localparam int unsigned BtnY     = 13;

	localparam logic [7:0] IdGip    = 8'h20;
	localparam logic [7:0] IdX360   = 8'h00;
	localparam logic [7:0] IdPs     = 8'h01;
	localparam logic [7:0] IdPacked = 8'h30;

	localparam int unsigned LenGip16    = 18;
	localparam int unsigned LenX360     = 14;
	localparam int unsigned LenDs4      = 10;
	localparam int unsigned LenDs3      = 10;
	localparam int unsigned LenDs5      = 11;
	localparam int unsigned LenPacked12 = 12;
	localparam int unsigned Ds3LtByte   = 18;
	localparam int unsigned Ds3RtByte   = 19;

	function automatic logic [13:0] hat_face(logic [7:0] b);
		logic [13:0] r;
		r = '0;
		unique case (b[3:0])
			4'd0: r[BtnUp] = 1'b1;
			4'd1: begin
				r[BtnUp]    = 1'b1;
				r[BtnRight] = 1'b1;
			end
			4'd2: r[BtnRight] = 1'b1;
			4'd3: begin
				r[BtnRight] = 1'b1;
				r[BtnDown]  = 1'b1;
			end
			4'd4: r[BtnDown] = 1'b1;
			4'd5: begin
				r[BtnDown] = 1'b1;
				r[BtnLeft] = 1'b1;
			end
			4'd6: r[BtnLeft] = 1'b1;
			4'd7: begin
				r[BtnLeft] = 1'b1;
				r[BtnUp]   = 1'b1;
			end
			default: r = '0;	// released hat
		endcase
		r[BtnX] = b[4];
		r[BtnA] = b[5];
		r[BtnB] = b[6];
		r[BtnY] = b[7];
		return r;
	endfunction

	function automatic logic [13:0] shoulders(logic [7:0] b);
		logic [13:0] r;
		r = '0;
		r[BtnLb]    = b[0];
		r[BtnRb]    = b[1];
		r[BtnBack]  = b[4];
		r[BtnStart] = b[5];
		r[BtnL3]    = b[6];
		r[BtnR3]    = b[7];
		return r;
	endfunction

	// 8-bit centred at 0x80 -> signed 16
	function automatic logic [15:0] stick8(logic [7:0] v);
		return {~v[7], v[6:0], 8'h00};
	endfunction

	// (raw - 2048) * 16, low 16 bits
	function automatic logic [15:0] stick12(logic [11:0] raw);
		return {~raw[11], raw[10:0], 4'h0};
	endfunction

	function automatic logic [15:0] neg16(logic [15:0] v);
		return ~v + 16'd1;
	endfunction

	report_bytes_t rb;
	assign rb = frame_bytes;

	always_comb begin
		pad_state = '0;
		report_ok = 1'b0;
		unique case (pad_format)
			FmtGip16: begin
				report_ok = (frame_len >= CNT_W'(LenGip16)) && (rb[0] == IdGip);
				pad_state.buttons[BtnStart] = rb[4][2];
				pad_state.buttons[BtnBack]  = rb[4][3];
				pad_state.buttons[BtnA]     = rb[4][4];
				pad_state.buttons[BtnB]     = rb[4][5];
				pad_state.buttons[BtnX]     = rb[4][6];
				pad_state.buttons[BtnY]     = rb[4][7];
				pad_state.buttons[BtnUp]    = rb[5][0];
				pad_state.buttons[BtnDown]  = rb[5][1];
				pad_state.buttons[BtnLeft]  = rb[5][2];
				pad_state.buttons[BtnRight] = rb[5][3];
				pad_state.buttons[BtnLb]    = rb[5][4];
				pad_state.buttons[BtnRb]    = rb[5][5];
				pad_state.buttons[BtnL3]    = rb[5][6];
				pad_state.buttons[BtnR3]    = rb[5][7];
				// 10-bit triggers, top 8 bits kept
				pad_state.triggers[0] = {rb[7][1:0], rb[6][7:2]};
				pad_state.triggers[1] = {rb[9][1:0], rb[8][7:2]};
				pad_state.axes[0] = {rb[11], rb[10]};
				pad_state.axes[1] = ~{rb[13], rb[12]};
				pad_state.axes[2] = {rb[15], rb[14]};
				pad_state.axes[3] = ~{rb[17], rb[16]};
			end
			FmtX360: begin
				report_ok = (frame_len >= CNT_W'(LenX360)) && (rb[0] == IdX360);
				pad_state.buttons[BtnUp]    = rb[2][0];
				pad_state.buttons[BtnDown]  = rb[2][1];
				pad_state.buttons[BtnLeft]  = rb[2][2];
				pad_state.buttons[BtnRight] = rb[2][3];
				pad_state.buttons[BtnStart] = rb[2][4];
				pad_state.buttons[BtnBack]  = rb[2][5];
				pad_state.buttons[BtnL3]    = rb[2][6];
				pad_state.buttons[BtnR3]    = rb[2][7];
				pad_state.buttons[BtnLb]    = rb[3][0];
				pad_state.buttons[BtnRb]    = rb[3][1];
				pad_state.buttons[BtnA]     = rb[3][4];
				pad_state.buttons[BtnB]     = rb[3][5];
				pad_state.buttons[BtnX]     = rb[3][6];
				pad_state.buttons[BtnY]     = rb[3][7];
				pad_state.triggers[0] = rb[4];
				pad_state.triggers[1] = rb[5];
				pad_state.axes[0] = {rb[7], rb[6]};
				pad_state.axes[1] = ~{rb[9], rb[8]};
				pad_state.axes[2] = {rb[11], rb[10]};
				pad_state.axes[3] = ~{rb[13], rb[12]};
			end
			FmtDs4: begin
				report_ok = (frame_len >= CNT_W'(LenDs4)) && (rb[0] == IdPs);
				pad_state.axes[0] = stick8(rb[1]);
				pad_state.axes[1] = stick8(rb[2]);
				pad_state.axes[2] = stick8(rb[3]);
				pad_state.axes[3] = stick8(rb[4]);
				pad_state.buttons = hat_face(rb[5]) | shoulders(rb[6]);
				pad_state.triggers[0] = rb[8];
				pad_state.triggers[1] = rb[9];
			end
			FmtDs3: begin
				report_ok = (frame_len >= CNT_W'(LenDs3)) && (rb[0] == IdPs);
				pad_state.buttons[BtnBack]  = rb[2][0];
				pad_state.buttons[BtnL3]    = rb[2][1];
				pad_state.buttons[BtnR3]    = rb[2][2];
				pad_state.buttons[BtnStart] = rb[2][3];
				pad_state.buttons[BtnUp]    = rb[2][4];
				pad_state.buttons[BtnRight] = rb[2][5];
				pad_state.buttons[BtnDown]  = rb[2][6];
				pad_state.buttons[BtnLeft]  = rb[2][7];
				pad_state.buttons[BtnLb]    = rb[3][2];
				pad_state.buttons[BtnRb]    = rb[3][3];
				pad_state.buttons[BtnY]     = rb[3][4];
				pad_state.buttons[BtnA]     = rb[3][5];
				pad_state.buttons[BtnB]     = rb[3][6];
				pad_state.buttons[BtnX]     = rb[3][7];
				pad_state.axes[0] = stick8(rb[6]);
				pad_state.axes[1] = stick8(rb[7]);
				pad_state.axes[2] = stick8(rb[8]);
				pad_state.axes[3] = stick8(rb[9]);
				// trigger bytes beyond a short report read as released
				pad_state.triggers[0] = (frame_len > CNT_W'(Ds3LtByte)) ? rb[Ds3LtByte] : 8'h00;
				pad_state.triggers[1] = (frame_len > CNT_W'(Ds3RtByte)) ? rb[Ds3RtByte] : 8'h00;
			end
			FmtDs5: begin
				report_ok = (frame_len >= CNT_W'(LenDs5)) && (rb[0] == IdPs);
				pad_state.axes[0] = stick8(rb[1]);
				pad_state.axes[1] = stick8(rb[2]);
				pad_state.axes[2] = stick8(rb[3]);
				pad_state.axes[3] = stick8(rb[4]);
				pad_state.triggers[0] = rb[5];
				pad_state.triggers[1] = rb[6];
				pad_state.buttons = hat_face(rb[8]) | shoulders(rb[9]);
			end
			FmtPacked12: begin
				report_ok = (frame_len >= CNT_W'(LenPacked12)) && (rb[0] == IdPacked);
				pad_state.buttons[BtnY]     = rb[3][0];
				pad_state.buttons[BtnX]     = rb[3][1];
				pad_state.buttons[BtnB]     = rb[3][2];
				pad_state.buttons[BtnA]     = rb[3][3];
				pad_state.buttons[BtnRb]    = rb[3][6];
				pad_state.buttons[BtnBack]  = rb[4][0];
				pad_state.buttons[BtnStart] = rb[4][1];
				pad_state.buttons[BtnR3]    = rb[4][2];
				pad_state.buttons[BtnL3]    = rb[4][3];
				pad_state.buttons[BtnDown]  = rb[5][0];
				pad_state.buttons[BtnUp]    = rb[5][1];
				pad_state.buttons[BtnRight] = rb[5][2];
				pad_state.buttons[BtnLeft]  = rb[5][3];
				pad_state.buttons[BtnLb]    = rb[5][6];
				// digital triggers
				pad_state.triggers[0] = {8{rb[5][7]}};
				pad_state.triggers[1] = {8{rb[3][7]}};
				pad_state.axes[0] = stick12({rb[7][3:0], rb[6]});
				pad_state.axes[1] = neg16(stick12({rb[8], rb[7][7:4]}));
				pad_state.axes[2] = stick12({rb[10][3:0], rb[9]});
				pad_state.axes[3] = neg16(stick12({rb[11], rb[10][7:4]}));
			end
			default: report_ok = 1'b0;
		endcase
	end

endmodule

>>> hw/rtl/gamepad_report_decoder_top.sv
// Gamepad report decoder: top level, layout register and held pad state.
// Depends on grd_pkg, grd_capture, grd_decode and gamepad_report_decoder_top_macros.svh.
//
// Report bytes stream in one per transaction, tlast on the final byte, and the
// block takes one byte per cycle sustained unless a final byte waits for the
// result register. Each byte goes through an input register; the final byte is
// decoded in the cycle it leaves that register and its result is valid on the
// master side in the next cycle. Only final bytes yield a result. The single result
// register holds the pad state; while a result waits, non-final bytes keep
// flowing and one final byte may wait in the input register. A rejected report
// (short, wrong id, or layout code 6 or 7) repeats the held state with
// tuser low. Write cfg_data only while no report is in flight.
`include "gamepad_report_decoder_top_macros.svh"

module gamepad_report_decoder_top #(
	parameter int unsigned REPORT_MAX_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,		// pad_format
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,	// [7:0] data_byte
	input  logic        s_axis_tlast,	// last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [13:0] buttons, [29:14] left_x, [45:30] left_y, [61:46] right_x,
	// [77:62] right_y, [85:78] left_trigger, [93:86] right_trigger, [95:94] zero
	output logic [95:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser	// [0] report_accepted
);
	import grd_pkg::*;

	localparam int unsigned CntW = $clog2(REPORT_MAX_BYTES + 1);

	logic [2:0]      pad_format_q;
	logic            slot_free;
	logic            frame_done;
	logic [CntW-1:0] frame_len;
	report_bytes_t   frame_bytes;
	pad_state_t      dec_state;
	logic            dec_ok;
	pad_state_t      held_q;
	logic            accepted_q;
	logic            out_valid_q;

	assign slot_free = !out_valid_q || m_axis_tready;

	grd_capture #(
		.REPORT_MAX_BYTES(REPORT_MAX_BYTES),
		.CNT_W(CntW)
	) u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_byte(s_axis_tdata),
		.in_last(s_axis_tlast),
		.slot_free(slot_free),
		.frame_done(frame_done),
		.frame_len(frame_len),
		.frame_bytes(frame_bytes)
	);

	grd_decode #(
		.CNT_W(CntW)
	) u_decode (
		.pad_format(pad_format_q),
		.frame_len(frame_len),
		.frame_bytes(frame_bytes),
		.pad_state(dec_state),
		.report_ok(dec_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_format_q <= FmtGip16;
			held_q       <= '0;
			accepted_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				pad_format_q <= cfg_data;
			end
			if (frame_done) begin
				out_valid_q <= 1'b1;
				accepted_q  <= dec_ok;
				if (dec_ok) begin
					held_q <= dec_state;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, held_q.triggers[1], held_q.triggers[0],
		held_q.axes[3], held_q.axes[2], held_q.axes[1], held_q.axes[0],
		held_q.buttons};
	assign m_axis_tuser  = accepted_q;

	`GRD_ASSERT_NEXT(a_reject_holds, clk, arst_n, frame_done && !dec_ok, $stable(held_q))
	`GRD_ASSERT(a_no_overwrite, clk, arst_n, frame_done |-> slot_free)
	`GRD_ASSERT_NEXT(a_bad_format, clk, arst_n, frame_done && (pad_format_q > FmtPacked12), !accepted_q)

endmodule
